@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ hdl/chrl_pkg.sv @@
// ---------------------------------------------------------------------------
// chrl_pkg
// Types, constants and the CRC-32 byte update shared by the ring lookup block.
// ---------------------------------------------------------------------------
package chrl_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int HASH_W         = 32;
   localparam int SERVER_W       = 8;
   localparam int STATUS_W       = 2;
   localparam int TOTAL_W        = 9;
   localparam int BYTE_W         = 8;

   localparam logic [HASH_W-1:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [HASH_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

   // Result codes
   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED = 2'd0,
      ST_FOUND = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_ADD_CHECK,
      S_INS_RD,
      S_INS_CMP,
      S_INS_ZERO,
      S_LOOK_CHECK,
      S_SRCH,
      S_SRCH_CMP,
      S_OWN,
      S_RESULT
   } state_type;

   // Table read address source
   typedef enum logic [1:0] {
      RD_IDX,
      RD_MID,
      RD_POS
   } rd_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       take_byte;
      logic       take_last;
      logic       ins_start;
      logic       idx_dec;
      logic       srch_start;
      logic       srch_step;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      logic       wr_new;
      logic       wr_zero;
      logic       cnt_inc;
      logic       own_load;
      logic       rsp_load;
      status_type code;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic full;
      logic empty;
      logic rd_greater;
      logic srch_open;
      logic idx_zero;
      logic rsp_busy;
   } stat_type;

   // Reflected CRC-32 update by one byte
   function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [HASH_W-1:0] c;
      c = crc ^ {{(HASH_W-BYTE_W){1'b0}}, data};
      for (int b = 0; b < BYTE_W; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ hdl/consistent_hash_ring_lookup.sv @@
// ---------------------------------------------------------------------------
// consistent_hash_ring_lookup
// Consistent-hash ring: CRC-32 key hashing, sorted point table, successor
// lookup with wrap to the smallest point.
// ---------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_ready  req_type, key_byte, last_byte, server_id
//  rsp       out        rsp_valid / rsp_ready  status, found_server, point_total
//
// Bytes that are not the last stream back to back.
// An add shifts each stored point above the new hash up one entry (one table
// RAM read and one write per shifted entry) and writes the new point above
// the first point not above it, or at the bottom; a full add does neither.
// A lookup runs a binary search over the registered-read table RAM, then
// reads the owner of the point found; an empty lookup skips both.
// Reset clears the count and the running CRC; the table needs no clearing
// pass. A held result stalls the next operation at its result step, and no
// byte of the operation after it is taken until the held result is sent.
// ---------------------------------------------------------------------------
module consistent_hash_ring_lookup import chrl_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_type,
   input  logic [BYTE_W-1:0]   req_key_byte,
   input  logic                req_last_byte,
   input  logic [SERVER_W-1:0] req_server_id,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SERVER_W-1:0] rsp_found_server,
   output logic [TOTAL_W-1:0]  rsp_point_total
);

   cmd_type  cmd;
   stat_type stat;

   chrl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_last_byte (req_last_byte),
      .stat          (stat),
      .cmd           (cmd)
   );

   chrl_dpath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_key_byte     (req_key_byte),
      .req_server_id    (req_server_id),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_found_server (rsp_found_server),
      .rsp_point_total  (rsp_point_total)
   );

endmodule

@@ hdl/chrl_ram.sv @@
// ---------------------------------------------------------------------------
// chrl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module chrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/chrl_ctrl.sv @@
// ---------------------------------------------------------------------------
// chrl_ctrl
// Sequencer for byte intake, sorted insert, lower-bound search and result.
// ---------------------------------------------------------------------------
module chrl_ctrl import chrl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  logic     req_type,
   input  logic     req_last_byte,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type  state_ff, state_in;
   status_type code_ff, code_in;

   // State and result code registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_ADDED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.rd_sel = RD_IDX;
      cmd.code   = code_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_byte = 1'b1;
               if (req_last_byte) begin
                  cmd.take_last = 1'b1;
                  state_in = req_type ? S_LOOK_CHECK : S_ADD_CHECK;
               end
            end
         end
         S_ADD_CHECK: begin
            if (stat.full) begin
               code_in  = ST_FULL;
               state_in = S_RESULT;
            end else if (stat.empty) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_new  = 1'b1;
               cmd.wr_zero = 1'b1;
               cmd.cnt_inc = 1'b1;
               code_in     = ST_ADDED;
               state_in    = S_RESULT;
            end else begin
               cmd.ins_start = 1'b1;
               state_in      = S_INS_RD;
            end
         end
         S_INS_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_IDX;
            state_in   = S_INS_CMP;
         end
         S_INS_CMP: begin
            // Shift a larger entry up, or drop the new point in above a smaller or equal one
            cmd.wr_en = 1'b1;
            if (stat.rd_greater) begin
               if (stat.idx_zero) begin
                  state_in = S_INS_ZERO;
               end else begin
                  cmd.idx_dec = 1'b1;
                  state_in    = S_INS_RD;
               end
            end else begin
               cmd.wr_new  = 1'b1;
               cmd.cnt_inc = 1'b1;
               code_in     = ST_ADDED;
               state_in    = S_RESULT;
            end
         end
         S_INS_ZERO: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_new  = 1'b1;
            cmd.wr_zero = 1'b1;
            cmd.cnt_inc = 1'b1;
            code_in     = ST_ADDED;
            state_in    = S_RESULT;
         end
         S_LOOK_CHECK: begin
            if (stat.empty) begin
               code_in  = ST_EMPTY;
               state_in = S_RESULT;
            end else begin
               cmd.srch_start = 1'b1;
               state_in       = S_SRCH;
            end
         end
         S_SRCH: begin
            cmd.rd_en = 1'b1;
            if (stat.srch_open) begin
               cmd.rd_sel = RD_MID;
               state_in   = S_SRCH_CMP;
            end else begin
               cmd.rd_sel = RD_POS;
               state_in   = S_OWN;
            end
         end
         S_SRCH_CMP: begin
            cmd.srch_step = 1'b1;
            state_in      = S_SRCH;
         end
         S_OWN: begin
            cmd.own_load = 1'b1;
            code_in      = ST_FOUND;
            state_in     = S_RESULT;
         end
         S_RESULT: begin
            // Hold until the output register is free
            if (!stat.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/chrl_dpath.sv @@
// ---------------------------------------------------------------------------
// chrl_dpath
// CRC register, point table, insert and search pointers, output register.
// ---------------------------------------------------------------------------
module chrl_dpath import chrl_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [BYTE_W-1:0]   req_key_byte,
   input  logic [SERVER_W-1:0] req_server_id,
   input  cmd_type             cmd,
   output stat_type            stat,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [SERVER_W-1:0] rsp_found_server,
   output logic [TOTAL_W-1:0]  rsp_point_total
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int ENT_W = HASH_W + SERVER_W;

   logic [HASH_W-1:0]   crc_ff, hash_ff;
   logic [SERVER_W-1:0] server_ff, owner_ff;
   logic [CW-1:0]       count_ff, lo_ff, hi_ff;
   logic [AW-1:0]       idx_ff;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SERVER_W-1:0] rsp_server_ff;
   logic [TOTAL_W-1:0]  rsp_total_ff;

   logic [HASH_W-1:0]      crc_in;
   logic [CW:0]            lohi_sum;
   logic [CW-1:0]          mid, cnt_m1;
   logic [AW-1:0]          idx_p1, pos, rd_addr, wr_addr;
   logic [ENT_W-1:0]       rd_data, wr_data;
   logic [HASH_W-1:0]      rd_hash;
   logic [SERVER_W-1:0]    rd_owner;
   logic [CW+TOTAL_W-1:0]  total_ext;

   assign crc_in   = crc_byte(crc_ff, req_key_byte);
   assign lohi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid      = lohi_sum[CW:1];
   assign cnt_m1   = count_ff - CW'(1);
   assign idx_p1   = idx_ff + AW'(1);
   assign pos      = (lo_ff == count_ff) ? '0 : lo_ff[AW-1:0];
   assign rd_hash  = rd_data[ENT_W-1:SERVER_W];
   assign rd_owner = rd_data[SERVER_W-1:0];
   assign total_ext = {{TOTAL_W{1'b0}}, count_ff};

   // Table address and data selection
   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:  rd_addr = idx_ff;
         RD_MID:  rd_addr = mid[AW-1:0];
         RD_POS:  rd_addr = pos;
         default: rd_addr = idx_ff;
      endcase
      wr_addr = cmd.wr_zero ? '0 : idx_p1;
      wr_data = cmd.wr_new ? {hash_ff, server_ff} : rd_data;
   end

   chrl_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Running CRC and point count
   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         count_ff <= '0;
      end else begin
         if (cmd.take_byte) begin
            crc_ff <= cmd.take_last ? CRC_INIT : crc_in;
         end
         if (cmd.cnt_inc) begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   // Capture key hash and server, advance insert and search pointers
   always_ff @(posedge clock) begin
      if (cmd.take_last) begin
         hash_ff   <= ~crc_in;
         server_ff <= req_server_id;
      end
      if (cmd.ins_start) begin
         idx_ff <= cnt_m1[AW-1:0];
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - AW'(1);
      end
      if (cmd.srch_start) begin
         lo_ff <= '0;
         hi_ff <= count_ff;
      end else if (cmd.srch_step) begin
         if (rd_hash < hash_ff) begin
            lo_ff <= mid + CW'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.own_load) begin
         owner_ff <= rd_owner;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.code;
         rsp_server_ff <= (cmd.code == ST_FOUND) ? owner_ff : '0;
         rsp_total_ff  <= total_ext[TOTAL_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found_server = rsp_server_ff;
   assign rsp_point_total  = rsp_total_ff;

   // Status back to the controller
   assign stat.full       = (count_ff == CW'(MAX_POINTS));
   assign stat.empty      = (count_ff == '0);
   assign stat.rd_greater = (rd_hash > hash_ff);
   assign stat.srch_open  = (lo_ff < hi_ff);
   assign stat.idx_zero   = (idx_ff == '0);
   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;

endmodule

@@ hdl/chrl_checker.sv @@
// ---------------------------------------------------------------------------
// chrl_checker
// Port-level checks on the ring lookup result channel.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module chrl_checker import chrl_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_type,
   input logic [BYTE_W-1:0]   req_key_byte,
   input logic                req_last_byte,
   input logic [SERVER_W-1:0] req_server_id,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [SERVER_W-1:0] rsp_found_server,
   input logic [TOTAL_W-1:0]  rsp_point_total
);

   // Hold a stalled transaction
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found_server) && $stable(rsp_point_total))

   // Empty-table result carries no server and no points
   `ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && (rsp_status == ST_EMPTY), (rsp_point_total == '0) && (rsp_found_server == '0))

   // Add results carry no server
   `ASSERT_IMPLY(a_add_no_server, clock, reset, rsp_valid && ((rsp_status == ST_ADDED) || (rsp_status == ST_FULL)), rsp_found_server == '0)

   // No result in the cycle after reset
   `ASSERT_IMPLY(a_reset_quiet, clock, reset, $past(reset), !rsp_valid)

endmodule

bind consistent_hash_ring_lookup chrl_checker u_chrl_checker (.*);
